// File: rtl/pvd_pkg.sv
// shared constants and types for the polynomial value and derivative block
package pvd_pkg;

  // coefficient table geometry
  localparam int MaxDegree = 15;
  localparam int Depth     = MaxDegree + 1;
  localparam int AddrW     = $clog2(Depth);

  // field widths
  localparam int IdxW  = 4;
  localparam int DegW  = 4;
  localparam int QW    = 32;
  localparam int FracW = 16;
  localparam int ProdW = 2 * QW;
  localparam int ShW   = ProdW - FracW;
  localparam int SumW  = ShW + 1;

  // stream payload widths
  localparam int InDataW  = 72;
  localparam int OutDataW = 64;

  // request kinds carried on tuser
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqEval = 1'b1;

  // control from the sequencer to the horner datapath
  typedef struct packed {
    logic init;
    logic mul;
    logic add;
  } step_ctl_t;

endpackage

// File: rtl/polynomial_value_and_derivative.sv
// top level: stream front end, horner sequencer and output register
//
// Holds up to sixteen signed Q16.16 coefficients and evaluates the polynomial
// and its first derivative at a point x by Horner's rule.
// Input stream s_axis: tuser selects the request. A load (tuser 0) writes
// one coefficient and gives no output transfer; an evaluate (tuser 1) gives
// exactly one output transfer on m_axis with value, derivative and an
// overflow flag on tuser.
// The degree register is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, the block itself does not enforce this.
// Sequence: an evaluate reads the top coefficient and initialises both chains,
// then runs each Horner step as a coefficient read with the registered multiply
// followed by the add/saturate, and finally loads the output register, at which
// point s_axis_tready returns. One item is in work at a time.
// The result sits in an output register, so loads and the next evaluate are
// taken while the receiver stalls; a finished evaluate waits in place until
// that register is free.
// Reset clears the degree, marks every coefficient as zero and empties the
// output register.
module polynomial_value_and_derivative
  import pvd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [DegW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // coef_index[3:0], coef_value[35:4], x_value[67:36], zero pad [71:68]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type[0]
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // poly_value[31:0], deriv_value[63:32]
  output logic [OutDataW-1:0] m_axis_tdata,
  // overflow[0]
  output logic [0:0]          m_axis_tuser
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StInit = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [AddrW-1:0]     cnt_q, cnt_d;
  logic [DegW-1:0]      degree_q;
  logic [AddrW-1:0]     deg_eff;
  logic signed [QW-1:0] x_q;

  logic [IdxW-1:0]      in_idx;
  logic signed [QW-1:0] in_coef;
  logic signed [QW-1:0] in_x;
  logic                 in_xfer, load_xfer, eval_xfer;

  logic                 mem_we, mem_re;
  logic [AddrW-1:0]     mem_raddr;
  logic signed [QW-1:0] mem_rdata;

  step_ctl_t            ctl;
  logic signed [QW-1:0] poly, deriv;
  logic                 ovf;

  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;
  logic                 out_ovf_q;
  logic                 out_load;

  // payload unpacking
  assign in_idx  = s_axis_tdata[IdxW-1:0];
  assign in_coef = s_axis_tdata[IdxW+QW-1:IdxW];
  assign in_x    = s_axis_tdata[IdxW+2*QW-1:IdxW+QW];

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign load_xfer     = in_xfer && (s_axis_tuser[0] == ReqLoad);
  assign eval_xfer     = in_xfer && (s_axis_tuser[0] == ReqEval);

  // degree register, clamped to the table size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
    end else if (cfg_we_i) begin
      degree_q <= cfg_wdata_i;
    end
  end
  assign deg_eff = (int'(degree_q) > MaxDegree) ? AddrW'(MaxDegree) : AddrW'(degree_q);

  // memory access: loads write, evaluate reads the top entry then one per step
  assign mem_we    = load_xfer && (int'(in_idx) <= MaxDegree);
  assign mem_re    = eval_xfer || (state_q == StMul);
  assign mem_raddr = (state_q == StMul) ? cnt_q : deg_eff;

  pvd_coef_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (AddrW'(in_idx)),
    .wdata_i (in_coef),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ctl      = '0;
    out_load = 1'b0;
    case (state_q)
      StIdle: begin
        if (eval_xfer) begin
          cnt_d   = deg_eff;
          state_d = StInit;
        end
      end
      StInit: begin
        ctl.init = 1'b1;
        if (cnt_q == '0) begin
          state_d = StDone;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = StMul;
        end
      end
      StMul: begin
        ctl.mul = 1'b1;
        state_d = StAdd;
      end
      StAdd: begin
        ctl.add = 1'b1;
        if (cnt_q == '0) begin
          state_d = StDone;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = StMul;
        end
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // evaluation point
  always_ff @(posedge clk_i) begin
    if (eval_xfer) begin
      x_q <= in_x;
    end
  end

  pvd_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .x_i     (x_q),
    .coef_i  (mem_rdata),
    .poly_o  (poly),
    .deriv_o (deriv),
    .ovf_o   (ovf)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {deriv, poly};
      out_ovf_q  <= ovf;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_ovf_q;

endmodule

// File: rtl/pvd_coef_mem.sv
// coefficient memory with per-entry valid bits and one registered read port
module pvd_coef_mem
  import pvd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic signed [QW-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic signed [QW-1:0] rdata_o
);

  logic signed [QW-1:0] mem [Depth];
  logic [Depth-1:0]     valid_q;
  logic signed [QW-1:0] rdata_q;
  logic                 rvld_q;

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= valid_q[raddr_i];
      end
    end
  end

  // storage array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/pvd_step.sv
// horner datapath: value and derivative chains, rounding multiply, saturation
module pvd_step
  import pvd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  step_ctl_t            ctl_i,
  input  logic signed [QW-1:0] x_i,
  input  logic signed [QW-1:0] coef_i,
  output logic signed [QW-1:0] poly_o,
  output logic signed [QW-1:0] deriv_o,
  output logic                 ovf_o
);

  logic signed [QW-1:0]    p_q, p_d, d_q, d_d;
  logic                    ovf_q, ovf_d;
  logic signed [ProdW-1:0] pm_q, dm_q;
  logic signed [ProdW-1:0] pm_rnd, dm_rnd;
  logic signed [ShW-1:0]   pm_sh, dm_sh;
  logic signed [SumW-1:0]  p_sum, d_sum;
  logic                    p_in, d_in;

  // products of both chains with x, registered
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      pm_q <= p_q * x_i;
      dm_q <= d_q * x_i;
    end
  end

  // round half up, then floor shift by the fraction width
  assign pm_rnd = pm_q + ProdW'(1 << (FracW - 1));
  assign dm_rnd = dm_q + ProdW'(1 << (FracW - 1));
  assign pm_sh  = pm_rnd[ProdW-1:FracW];
  assign dm_sh  = dm_rnd[ProdW-1:FracW];

  // accumulate: derivative takes the old value, value takes the coefficient
  assign d_sum = SumW'(dm_sh) + SumW'(p_q);
  assign p_sum = SumW'(pm_sh) + SumW'(coef_i);

  // in range when all bits above the sign agree
  assign p_in = (&p_sum[SumW-1:QW-1]) || !(|p_sum[SumW-1:QW-1]);
  assign d_in = (&d_sum[SumW-1:QW-1]) || !(|d_sum[SumW-1:QW-1]);

  // next chain values
  always_comb begin
    p_d   = p_q;
    d_d   = d_q;
    ovf_d = ovf_q;
    if (ctl_i.init) begin
      p_d   = coef_i;
      d_d   = '0;
      ovf_d = 1'b0;
    end else if (ctl_i.add) begin
      if (p_in) begin
        p_d = p_sum[QW-1:0];
      end else begin
        p_d = p_sum[SumW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end
      if (d_in) begin
        d_d = d_sum[QW-1:0];
      end else begin
        d_d = d_sum[SumW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end
      ovf_d = ovf_q || !p_in || !d_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else begin
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    d_q <= d_d;
  end

  assign poly_o  = p_q;
  assign deriv_o = d_q;
  assign ovf_o   = ovf_q;

endmodule

// File: rtl/pvd_checker.sv
// port-level checks for the polynomial block and their binding
module pvd_checker
  import pvd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [0:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [0:0]          m_axis_tuser
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a load transfer never creates a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ReqLoad) && !m_axis_tvalid
      |=> !m_axis_tvalid)
    else $error("load produced a result");

  // an evaluate transfer makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ReqEval) |=> !s_axis_tready)
    else $error("evaluate did not occupy the block");

  // a new result appears only at the end of an evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without evaluation");

endmodule

bind polynomial_value_and_derivative pvd_checker u_pvd_checker (.*);
